@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define SFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication outside reset.
`define SFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sfp_pkg.sv @@
// Shared types, codes and constants of the sum-checked frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

    // Reset value of the max_length register
    localparam logic [15:0] MAX_LENGTH_RST = 16'd32767;

    // First header character, used to restart the hunt
    localparam logic [7:0] HEAD_FIRST = 8'h48;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SUM     = 3'd4,
        PH_TRAILER = 3'd5
    } t_phase;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD     = 3'd0,
        KIND_GOOD        = 3'd1,
        KIND_BAD_LENGTH  = 3'd2,
        KIND_BAD_SUM     = 3'd3,
        KIND_BAD_TRAILER = 3'd4
    } t_kind;

    // One result beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       frame_end;
    } t_result;

    // Header "HKQY"
    function automatic logic [7:0] head_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h48;
            2'd1:    c = 8'h4B;
            2'd2:    c = 8'h51;
            default: c = 8'h59;
        endcase
        return c;
    endfunction

    // Trailer "BZKJ"
    function automatic logic [7:0] tail_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h42;
            2'd1:    c = 8'h5A;
            2'd2:    c = 8'h4B;
            default: c = 8'h4A;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/sum_checked_frame_parser_top.sv @@
// Top level of the sum-checked frame parser.
// Takes one link byte per beat and finds frames of header "HKQY", 16-bit big-endian
// length, payload, 8-bit wrapping payload sum and trailer "BZKJ". Payload bytes come out
// as they arrive (kind 0); each attempt past the header closes with one status beat
// (good, bad length, bad checksum, bad trailer) with frame_end set; drop the payload of a
// frame whose status is not good. Throughput is one byte per cycle with no stall from
// the consumer. An accepted byte sits in the input register until the byte step takes it
// and, when the byte yields a result, writes that into the result register; a consumer
// stall holds the byte step back. max_length may be written only while the parser is
// idle; its reset value is 32767.
`timescale 1ns / 1ps

module sum_checked_frame_parser_top
    import sfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_end,
    // max_length write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_ready;
    logic       fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // Byte step fires when a byte is held and the result register is free
    assign fire        = in_valid && out_ready;
    assign o_cfg_ready = 1'b1;

    sfp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_take     (out_ready),
        .o_valid    (in_valid),
        .o_byte     (in_byte)
    );

    sfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (in_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (fire && res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_result_kind  = out_res.kind;
    assign o_payload_byte = out_res.data;
    assign o_frame_end    = out_res.frame_end;

endmodule

@@ rtl/core/sfp_in_stage.sv @@
// Input register of the frame parser: holds one received byte until the parser takes it.
`timescale 1ns / 1ps

module sfp_in_stage
    import sfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       accept;

    // Stall only when a held beat cannot move on this cycle
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_take);
        end
    end

    // Byte register, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ rtl/core/sfp_parser.sv @@
// Frame parser state machine: one byte step per cycle in which a byte fires, plus the max_length register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfp_parser
    import sfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_match,  n_match;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_remain, n_remain;
    logic [7:0]  r_sum,    n_sum;
    logic [15:0] r_max;
    logic [15:0] len_full;

    assign len_full = {r_len[15:8], i_byte};

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_match  <= 2'd0;
            r_len    <= 16'd0;
            r_remain <= 16'd0;
            r_sum    <= 8'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_len    <= n_len;
            r_remain <= n_remain;
            r_sum    <= n_sum;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    // Next state and result for the byte in hand
    always_comb begin
        n_phase        = r_phase;
        n_match        = r_match;
        n_len          = r_len;
        n_remain       = r_remain;
        n_sum          = r_sum;
        o_res_valid    = 1'b0;
        o_res.kind     = KIND_PAYLOAD;
        o_res.data     = 8'd0;
        o_res.frame_end = 1'b0;

        case (r_phase)
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'd0};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = len_full;
                if (len_full > r_max) begin
                    n_phase         = PH_HUNT;
                    n_match         = 2'd0;
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_BAD_LENGTH;
                    o_res.frame_end = 1'b1;
                end else begin
                    n_sum    = 8'd0;
                    n_remain = len_full;
                    n_phase  = (len_full == 16'd0) ? PH_SUM : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum       = r_sum + i_byte;
                n_remain    = r_remain - 16'd1;
                if (r_remain == 16'd1) begin
                    n_phase = PH_SUM;
                end
                o_res_valid = 1'b1;
                o_res.kind  = KIND_PAYLOAD;
                o_res.data  = i_byte;
            end
            PH_SUM: begin
                if (i_byte != r_sum) begin
                    n_phase         = PH_HUNT;
                    n_match         = 2'd0;
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_BAD_SUM;
                    o_res.frame_end = 1'b1;
                end else begin
                    n_phase = PH_TRAILER;
                    n_match = 2'd0;
                end
            end
            PH_TRAILER: begin
                if (i_byte != tail_char(r_match)) begin
                    n_phase         = PH_HUNT;
                    n_match         = 2'd0;
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_BAD_TRAILER;
                    o_res.frame_end = 1'b1;
                end else if (r_match == 2'd3) begin
                    n_phase         = PH_HUNT;
                    n_match         = 2'd0;
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_GOOD;
                    o_res.frame_end = 1'b1;
                end else begin
                    n_match = r_match + 2'd1;
                end
            end
            default: begin
                // Header hunt; unused phase codes land here too
                n_phase = PH_HUNT;
                if (i_byte == head_char(r_match)) begin
                    if (r_match == 2'd3) begin
                        n_match = 2'd0;
                        n_phase = PH_LEN_HI;
                    end else begin
                        n_match = r_match + 2'd1;
                    end
                end else if (i_byte == HEAD_FIRST) begin
                    n_match = 2'd1;
                end else begin
                    n_match = 2'd0;
                end
            end
        endcase
    end

    // Checks
    `SFP_ASSERT_IMP(a_payload_count, r_phase == PH_PAYLOAD, r_remain != 16'd0, "payload phase with zero bytes left")
    `SFP_ASSERT_IMP(a_match_phase, r_match != 2'd0, r_phase == PH_HUNT || r_phase == PH_TRAILER, "match position set outside hunt or trailer")
    `SFP_ASSERT_IMP(a_payload_emits, i_fire && r_phase == PH_PAYLOAD, o_res_valid && o_res.kind == KIND_PAYLOAD && !o_res.frame_end, "payload byte not passed on")
    `SFP_ASSERT_NXT(a_hold_state, !i_fire, $stable(r_phase) && $stable(r_match) && $stable(r_remain), "parser state moved without a beat")

endmodule

@@ rtl/core/sfp_out_stage.sv @@
// Result register of the frame parser, with valid/stall handshake to the consumer.
`timescale 1ns / 1ps

module sfp_out_stage
    import sfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule
